// ----- hdl/pfde_pkg.sv -----
// Shared constants, types and helpers of the Playfair digraph encryption core.
`timescale 1ns / 1ps
package pfde_pkg;

  localparam int SQUARE_SIDE = 5;
  localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
  localparam int POS_W       = (SQUARE_SIDE > 1) ? $clog2(SQUARE_SIDE) : 1;
  localparam int LETTER_W    = 8;
  localparam int INDEX_W     = 5;

  localparam logic [LETTER_W-1:0] PAD_RESET = 8'd113;

  // Request kinds carried in the input tuser
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ENCRYPT = 1'b1;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef letter_t [CELL_COUNT-1:0] square_t;
  typedef letter_t [SQUARE_SIDE-1:0] line_t;

  // What one lookup lane found for its letter
  typedef struct packed {
    logic  hit;
    pos_t  row;
    pos_t  col;
    line_t row_cells;
    line_t col_cells;
  } loc_t;

  // Combined result of one digraph
  typedef struct packed {
    logic    not_found;
    letter_t cipher_second;
    letter_t cipher_first;
  } res_t;

  // Cyclic step to the next row or column
  function automatic pos_t next_pos(input pos_t pos);
    pos_t nxt;
    if (pos == pos_t'(SQUARE_SIDE - 1)) begin
      nxt = '0;
    end else begin
      nxt = pos + pos_t'(1);
    end
    return nxt;
  endfunction

endpackage

// ----- hdl/playfair_digraph_encrypt_core.sv -----
// Top level of the Playfair digraph encryption core.
//
//  channel  | direction | transfer when          | contents
//  ---------+-----------+------------------------+-----------------------------------
//  s_axis   | in        | s_tvalid & s_tready    | request: kind, cell load, digraph
//  m_axis   | out       | m_tvalid & m_tready    | cipher pair and not-found flag
//  cfg      | in        | cfg_valid & cfg_ready  | pad letter
//
// One item per cycle unless the output stalls; each result is registered at its transfer.
// Two lookup lanes search the 25-cell square for both letters in the same cycle and
// the merge stage picks the cipher letters; the result lands in one output register.
// A stalled output holds its register; the input still accepts when that register
// is being emptied in the same cycle.
// Reset (rst, synchronous) clears the square to zero and sets the pad to 'q'.
`timescale 1ns / 1ps
module playfair_digraph_encrypt_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cell_index[4:0], cell_letter[12:5], first_letter[20:13],
                                 // second_letter[28:21], zero fill [31:29]
  input  logic [0:0]  s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // cipher_first[7:0], cipher_second[15:8]
  output logic [0:0]  m_tuser,   // not_found[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // pad_letter
);

  pfde_pkg::square_t  key_square;
  pfde_pkg::letter_t  pad_letter;
  pfde_pkg::res_t     res_next;
  pfde_pkg::loc_t     loc_a;
  pfde_pkg::loc_t     loc_b;

  logic [pfde_pkg::INDEX_W-1:0] cell_index;
  pfde_pkg::letter_t cell_letter;
  pfde_pkg::letter_t first_letter;
  pfde_pkg::letter_t second_letter;
  pfde_pkg::letter_t partner;
  logic req_type;
  logic in_xfer;
  logic load_hit;

  // unpack the request
  assign req_type      = s_tuser[0];
  assign cell_index    = s_tdata[4:0];
  assign cell_letter   = s_tdata[12:5];
  assign first_letter  = s_tdata[20:13];
  assign second_letter = s_tdata[28:21];

  // the output register parts the two sides
  assign s_tready  = !m_tvalid || m_tready;
  assign in_xfer   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // a doubled pair takes the pad as its second letter
  assign partner = (first_letter == second_letter) ? pad_letter : second_letter;

  // drop loads beyond the square
  assign load_hit = in_xfer && (req_type == pfde_pkg::REQ_LOAD) &&
                    (32'(cell_index) < 32'(pfde_pkg::CELL_COUNT));

  pfde_locate u_lane_a (
    .square (key_square),
    .letter (first_letter),
    .loc    (loc_a)
  );

  pfde_locate u_lane_b (
    .square (key_square),
    .letter (partner),
    .loc    (loc_b)
  );

  pfde_merge u_merge (
    .loc_a (loc_a),
    .loc_b (loc_b),
    .res   (res_next)
  );

  // key square and pad register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_square <= '0;
      pad_letter <= pfde_pkg::PAD_RESET;
    end else begin
      if (load_hit) begin
        key_square[cell_index] <= cell_letter;
      end
      if (cfg_valid && cfg_ready) begin
        pad_letter <= cfg_data;
      end
    end
  end

  // output register: loads answer with all zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (req_type == pfde_pkg::REQ_ENCRYPT) begin
        m_tdata <= {res_next.cipher_second, res_next.cipher_first};
        m_tuser <= res_next.not_found;
      end else begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'd0))
    else $error("missing letter with non-zero cipher");

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (req_type == pfde_pkg::REQ_LOAD)) |=>
    (m_tvalid && (m_tdata == 16'd0) && (m_tuser == 1'b0)))
    else $error("load result not zero");

  a_pad_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg_valid |=> $stable(pad_letter))
    else $error("pad changed without a write");
`endif

endmodule

// ----- hdl/pfde_locate.sv -----
// Lookup lane: finds the last cell holding a letter and picks out its row and column.
`timescale 1ns / 1ps
module pfde_locate (
  input  pfde_pkg::square_t square,
  input  pfde_pkg::letter_t letter,
  output pfde_pkg::loc_t    loc
);

  always_comb begin
    logic        row_any;
    pfde_pkg::pos_t last_col;
    loc = '0;
    // scan in row-major order, the last match overrides earlier ones
    for (int r = 0; r < pfde_pkg::SQUARE_SIDE; r++) begin
      row_any  = 1'b0;
      last_col = '0;
      for (int c = 0; c < pfde_pkg::SQUARE_SIDE; c++) begin
        if (square[r * pfde_pkg::SQUARE_SIDE + c] == letter) begin
          row_any  = 1'b1;
          last_col = pfde_pkg::pos_t'(c);
        end
      end
      if (row_any) begin
        loc.hit = 1'b1;
        loc.row = pfde_pkg::pos_t'(r);
        loc.col = last_col;
      end
    end
    // gather the row and column through the located cell
    for (int r = 0; r < pfde_pkg::SQUARE_SIDE; r++) begin
      if (pfde_pkg::pos_t'(r) == loc.row) begin
        for (int c = 0; c < pfde_pkg::SQUARE_SIDE; c++) begin
          loc.row_cells[c] = square[r * pfde_pkg::SQUARE_SIDE + c];
        end
      end
    end
    for (int c = 0; c < pfde_pkg::SQUARE_SIDE; c++) begin
      if (pfde_pkg::pos_t'(c) == loc.col) begin
        for (int r = 0; r < pfde_pkg::SQUARE_SIDE; r++) begin
          loc.col_cells[r] = square[r * pfde_pkg::SQUARE_SIDE + c];
        end
      end
    end
  end

endmodule

// ----- hdl/pfde_merge.sv -----
// Merge stage: applies the row, column or rectangle rule to the two lane results.
`timescale 1ns / 1ps
module pfde_merge (
  input  pfde_pkg::loc_t loc_a,
  input  pfde_pkg::loc_t loc_b,
  output pfde_pkg::res_t res
);

  always_comb begin
    res = '0;
    if (!loc_a.hit || !loc_b.hit) begin
      res.not_found = 1'b1;
    end else if (loc_a.row == loc_b.row) begin
      res.cipher_first  = loc_a.row_cells[pfde_pkg::next_pos(loc_a.col)];
      res.cipher_second = loc_b.row_cells[pfde_pkg::next_pos(loc_b.col)];
    end else if (loc_a.col == loc_b.col) begin
      res.cipher_first  = loc_a.col_cells[pfde_pkg::next_pos(loc_a.row)];
      res.cipher_second = loc_b.col_cells[pfde_pkg::next_pos(loc_b.row)];
    end else begin
      // rectangle: own row, partner's column
      res.cipher_first  = loc_a.row_cells[loc_b.col];
      res.cipher_second = loc_b.row_cells[loc_a.col];
    end
  end

endmodule

// ----- sim/playfair_digraph_encrypt_core_tb.sv -----
// Self-checking testbench of the Playfair digraph encryption core.
`timescale 1ns / 1ps
module playfair_digraph_encrypt_core_tb;

  localparam int MAX_INDEX = (1 << pfde_pkg::INDEX_W) - 1;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // cell_index[4:0], cell_letter[12:5], first_letter[20:13],
                          // second_letter[28:21], zero fill [31:29]
  logic [0:0]  s_tuser;   // req_type[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // cipher_first[7:0], cipher_second[15:8]
  logic [0:0]  m_tuser;   // not_found[0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;  // pad_letter

  playfair_digraph_encrypt_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block's state: key square and pad letter as the core should hold them
  pfde_pkg::letter_t key_cells [pfde_pkg::CELL_COUNT];
  pfde_pkg::letter_t pad_now;

  // Cipher results owed by the core, oldest first
  pfde_pkg::res_t    cipher_due [$];
  int      error_count = 0;

  // Idling controls shared by sender, receiver and the test tasks
  logic    send_gaps = 1'b1;
  logic    recv_gaps = 1'b1;
  int      hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Row-major scan of the shadow square; the last matching cell wins
  function automatic logic find_letter(input pfde_pkg::letter_t letter, output int row,
                                       output int col);
    logic hit;
    hit = 1'b0;
    row = 0;
    col = 0;
    for (int i = 0; i < pfde_pkg::CELL_COUNT; i++) begin
      if (key_cells[i] == letter) begin
        hit = 1'b1;
        row = i / pfde_pkg::SQUARE_SIDE;
        col = i % pfde_pkg::SQUARE_SIDE;
      end
    end
    return hit;
  endfunction

  function automatic pfde_pkg::letter_t cell_at(input int row, input int col);
    return key_cells[(row % pfde_pkg::SQUARE_SIDE) * pfde_pkg::SQUARE_SIDE +
                     (col % pfde_pkg::SQUARE_SIDE)];
  endfunction

  // Expected cipher pair for one digraph under the current square and pad
  function automatic pfde_pkg::res_t encipher_pair(input pfde_pkg::letter_t first,
                                                   input pfde_pkg::letter_t second);
    pfde_pkg::res_t    res;
    pfde_pkg::letter_t partner;
    int      ra, ka, rb, kb;
    logic    hit_a, hit_b;
    res = '0;
    partner = (first == second) ? pad_now : second;
    hit_a = find_letter(first, ra, ka);
    hit_b = find_letter(partner, rb, kb);
    if (!hit_a || !hit_b) begin
      res.not_found = 1'b1;
    end else if (ra == rb) begin
      res.cipher_first  = cell_at(ra, ka + 1);
      res.cipher_second = cell_at(rb, kb + 1);
    end else if (ka == kb) begin
      res.cipher_first  = cell_at(ra + 1, ka);
      res.cipher_second = cell_at(rb + 1, kb);
    end else begin
      res.cipher_first  = cell_at(ra, kb);
      res.cipher_second = cell_at(rb, ka);
    end
    return res;
  endfunction

  // Drive one request from a falling edge and hold it until the transfer;
  // the shadow state advances at the accepting rising edge.
  task automatic send_item(input logic kind, input logic [pfde_pkg::INDEX_W-1:0] idx,
                           input pfde_pkg::letter_t cell_val,
                           input pfde_pkg::letter_t first,
                           input pfde_pkg::letter_t second);
    int gap;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {3'b000, second, first, cell_val, idx};
    do @(posedge clk); while (!s_tready);
    if (kind == pfde_pkg::REQ_LOAD) begin
      // out-of-range loads leave the square alone but still give a zero result
      if (idx < pfde_pkg::CELL_COUNT) key_cells[idx] = cell_val;
      cipher_due.push_back('0);
    end else begin
      cipher_due.push_back(encipher_pair(first, second));
    end
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Unused fields of each kind carry random noise
  task automatic load_cell(input int idx, input pfde_pkg::letter_t letter);
    send_item(pfde_pkg::REQ_LOAD, pfde_pkg::INDEX_W'(idx), letter,
              pfde_pkg::letter_t'($urandom), pfde_pkg::letter_t'($urandom));
  endtask

  task automatic encrypt_pair(input pfde_pkg::letter_t first, input pfde_pkg::letter_t second);
    send_item(pfde_pkg::REQ_ENCRYPT, pfde_pkg::INDEX_W'($urandom),
              pfde_pkg::letter_t'($urandom), first, second);
  endtask

  // Wait for every owed result, then let the output register settle
  task automatic wait_idle();
    while (cipher_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_pad(input pfde_pkg::letter_t pad);
    cfg_valid = 1'b1;
    cfg_data  = pad;
    do @(posedge clk); while (!cfg_ready);
    pad_now = pad;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Fill all cells: distinct letters, a narrow alphabet full of repeats, or raw bytes
  task automatic load_square(input int style);
    pfde_pkg::letter_t base, stride;
    base   = pfde_pkg::letter_t'($urandom);
    stride = pfde_pkg::letter_t'($urandom) | 8'd1;
    for (int i = 0; i < pfde_pkg::CELL_COUNT; i++) begin
      case (style)
        0: begin
          load_cell(i, base + pfde_pkg::letter_t'(stride * i));
        end
        1: begin
          load_cell(i, base + pfde_pkg::letter_t'($urandom_range(0, 7)));
        end
        default: begin
          load_cell(i, pfde_pkg::letter_t'($urandom));
        end
      endcase
    end
  endtask

  // Mostly digraphs drawn from the square, with doubled pairs, strays and a few loads
  task automatic random_items(input int count);
    int      roll;
    pfde_pkg::letter_t first, second;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        load_cell($urandom_range(pfde_pkg::CELL_COUNT, MAX_INDEX),
                  pfde_pkg::letter_t'($urandom));
      end else if (roll < 12) begin
        load_cell($urandom_range(0, pfde_pkg::CELL_COUNT - 1), pfde_pkg::letter_t'($urandom));
      end else begin
        first = (roll < 92) ? key_cells[$urandom_range(0, pfde_pkg::CELL_COUNT - 1)]
                            : pfde_pkg::letter_t'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          second = first;
        end else if ($urandom_range(0, 9) == 0) begin
          second = pfde_pkg::letter_t'($urandom);
        end else begin
          second = key_cells[$urandom_range(0, pfde_pkg::CELL_COUNT - 1)];
        end
        encrypt_pair(first, second);
      end
    end
  endtask

  // Fresh square after reset: every cell is zero, so only zero letters are found
  task automatic test_empty_square();
    encrypt_pair(8'd0, 8'd0);      // pad 'q' replaces the second letter and is absent
    encrypt_pair(8'hFF, 8'd0);     // first letter absent
    wait_idle();
    write_pad(8'd0);
    encrypt_pair(8'd0, 8'd0);      // both letters in one cell: moves right as one row
    encrypt_pair(8'd0, 8'hFF);     // second letter absent
    wait_idle();
  endtask

  // Textbook square, then the rule cases and the edges of the load index
  task automatic test_classic_square();
    string keyed;
    keyed = "playfirexmbcdghknoqstuvwz";
    write_pad("x");
    for (int i = 0; i < pfde_pkg::CELL_COUNT; i++) load_cell(i, pfde_pkg::letter_t'(keyed[i]));
    load_cell(pfde_pkg::CELL_COUNT, "z");    // beyond the square: ignored
    load_cell(MAX_INDEX, 8'hFF);   // highest index: ignored
    encrypt_pair("h", "i");        // rectangle
    encrypt_pair("p", "a");        // same row
    encrypt_pair("f", "p");        // same row, wraps to the first column
    encrypt_pair("p", "t");        // same column, wraps to the top row
    encrypt_pair("e", "e");        // doubled pair takes the pad
    encrypt_pair("j", "a");        // first absent
    encrypt_pair("a", "j");        // second absent
    load_cell(12, 8'hFF);
    load_cell(7, 8'd0);
    encrypt_pair(8'hFF, "a");
    encrypt_pair("a", 8'd0);
    load_cell(pfde_pkg::CELL_COUNT - 1, "p"); // duplicate letter: the later cell wins
    encrypt_pair("p", "l");
    wait_idle();
  endtask

  // Pad at its top value, then back to the reset default
  task automatic test_pad_extremes();
    write_pad(8'hFF);
    encrypt_pair("a", "a");
    encrypt_pair(8'hFF, 8'hFF);
    wait_idle();
    write_pad(pfde_pkg::PAD_RESET);
    encrypt_pair("c", "c");
    wait_idle();
  endtask

  // Starve the output for a long stretch while requests keep coming, so the
  // core fills up and drops its ready
  task automatic test_backpressure();
    send_gaps   = 1'b0;
    hold_cycles = 150;
    random_items(40);
    send_gaps   = 1'b1;
    wait_idle();
  endtask

  // Phases of new square, new pad and random traffic; the last phase runs flat out
  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      send_gaps = (phase < 7);
      recv_gaps = (phase < 7);
      load_square(phase % 3);
      wait_idle();
      if ($urandom_range(0, 1) == 0) begin
        write_pad(key_cells[$urandom_range(0, pfde_pkg::CELL_COUNT - 1)]);
      end else begin
        write_pad(pfde_pkg::letter_t'($urandom));
      end
      random_items(95);
      wait_idle();
    end
  endtask

  // Receiver: ready with random stall bursts, or one long hold when asked
  initial begin : output_ready
    int n;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Result checker: sample the transfer at the rising edge, then compare a moment
  // later so that a request accepted at the same edge has been predicted already
  initial begin : result_check
    logic [15:0] got_data;
    logic        got_flag;
    pfde_pkg::res_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got_data = m_tdata;
        got_flag = m_tuser[0];
        #1;
        if (cipher_due.size() == 0) begin
          report_mismatch("unexpected result", got_data, '0);
        end else begin
          want = cipher_due.pop_front();
          if (got_data[7:0] !== want.cipher_first)
            report_mismatch("cipher_first", 16'(got_data[7:0]), 16'(want.cipher_first));
          if (got_data[15:8] !== want.cipher_second)
            report_mismatch("cipher_second", 16'(got_data[15:8]), 16'(want.cipher_second));
          if (got_flag !== want.not_found)
            report_mismatch("not_found", 16'(got_flag), 16'(want.not_found));
        end
      end
    end
  end

  // Main sequence: reset once, run each test, drain, then give the verdict
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    for (int i = 0; i < pfde_pkg::CELL_COUNT; i++) key_cells[i] = '0;
    pad_now = pfde_pkg::PAD_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_empty_square();
    test_classic_square();
    test_pad_extremes();
    test_backpressure();
    test_random_phases();

    while (cipher_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
